// ----- rtl/pim_pkg.sv -----
// shared constants, result type and saturating helpers for the pair invariant mass block
package pim_pkg;

    localparam int DEF_MOMENTUM_BITS = 18;
    localparam int DEF_MASS_BITS     = 16;

    // squares and their sums are carried at 64 bits and saturate there
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int ESUM_W    = ROOT_W + 1;
    localparam int ISQRT_LAT = SQ_W / 2;

    // energy lane: square, two adder levels, root
    localparam int LANE_LAT  = ISQRT_LAT + 3;
    // momentum path in the merge stage: sum, square, two adder levels
    localparam int MOM_LAT   = 4;
    localparam int PIPE_LAT  = LANE_LAT + 3 + ISQRT_LAT;

    localparam int OUT_W      = 19;
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic [OUT_W-1:0] inv_mass;
        logic [OUT_W-1:0] pair_energy;
        logic             clamped;
    } t_result;

    function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                                input logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sat_sq(input logic [SQ_W-1:0] a);
        logic [ROOT_W-1:0] lo;
        lo = a[ROOT_W-1:0];
        if (a[SQ_W-1:ROOT_W] != '0) begin
            return {SQ_W{1'b1}};
        end
        return {{ROOT_W{1'b0}}, lo} * {{ROOT_W{1'b0}}, lo};
    endfunction

    // magnitude of a sign-extended two's complement value
    function automatic logic [SQ_W-1:0] mag64(input logic [SQ_W-1:0] x);
        return x[SQ_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

// ----- rtl/pim_isqrt.sv -----
// pipelined floor square root of a 64-bit value, one result bit per stage
module pim_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pim_pkg::SQ_W-1:0]    i_v,
    output logic [pim_pkg::ROOT_W-1:0]  o_root
);
    import pim_pkg::*;

    logic [SQ_W-1:0] v_in   [0:ISQRT_LAT-1];
    logic [SQ_W-1:0] res_in [0:ISQRT_LAT];

    assign v_in[0]   = i_v;
    assign res_in[0] = '0;

    for (genvar k = 0; k < ISQRT_LAT; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * k);

        logic [SQ_W-1:0] trial;
        logic            fits;
        logic [SQ_W-1:0] n_res;
        logic [SQ_W-1:0] r_res;

        assign trial = res_in[k] + BIT;
        assign fits  = (v_in[k] >= trial);

        always_comb begin
            if (fits) begin
                n_res = (res_in[k] >> 1) + BIT;
            end else begin
                n_res = res_in[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res <= n_res;
            end
        end
        assign res_in[k+1] = r_res;

        // the remainder is not needed after the last stage
        if (k < ISQRT_LAT - 1) begin : g_rem
            logic [SQ_W-1:0] n_v;
            logic [SQ_W-1:0] r_v;

            assign n_v = fits ? (v_in[k] - trial) : v_in[k];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v <= n_v;
                end
            end
            assign v_in[k+1] = r_v;
        end
    end

    assign o_root = res_in[ISQRT_LAT][ROOT_W-1:0];

endmodule

// ----- rtl/pim_energy_lane.sv -----
// one particle energy lane: floor sqrt of m^2 + px^2 + py^2 + pz^2
module pim_energy_lane #(
    parameter int MOMENTUM_BITS = pim_pkg::DEF_MOMENTUM_BITS,
    parameter int MASS_BITS     = pim_pkg::DEF_MASS_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [MOMENTUM_BITS-1:0]   i_px,
    input  logic signed [MOMENTUM_BITS-1:0]   i_py,
    input  logic signed [MOMENTUM_BITS-1:0]   i_pz,
    input  logic        [MASS_BITS-1:0]       i_mass,
    output logic        [pim_pkg::ROOT_W-1:0] o_energy
);
    import pim_pkg::*;

    logic [SQ_W-1:0] r_sq_m;
    logic [SQ_W-1:0] r_sq_x;
    logic [SQ_W-1:0] r_sq_y;
    logic [SQ_W-1:0] r_sq_z;
    logic [SQ_W-1:0] r_s01;
    logic [SQ_W-1:0] r_s23;
    logic [SQ_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_m <= sat_sq(SQ_W'(i_mass));
            r_sq_x <= sat_sq(mag64(SQ_W'(i_px)));
            r_sq_y <= sat_sq(mag64(SQ_W'(i_py)));
            r_sq_z <= sat_sq(mag64(SQ_W'(i_pz)));
            r_s01  <= sat_add(r_sq_m, r_sq_x);
            r_s23  <= sat_add(r_sq_y, r_sq_z);
            r_sum  <= sat_add(r_s01, r_s23);
        end
    end

    pim_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_v    (r_sum),
        .o_root (o_energy)
    );

endmodule

// ----- rtl/pim_merge.sv -----
// merge stage: pair energy, summed momentum squared, radicand and final root
module pim_merge #(
    parameter int MOMENTUM_BITS = pim_pkg::DEF_MOMENTUM_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [MOMENTUM_BITS-1:0]   i_first_px,
    input  logic signed [MOMENTUM_BITS-1:0]   i_first_py,
    input  logic signed [MOMENTUM_BITS-1:0]   i_first_pz,
    input  logic signed [MOMENTUM_BITS-1:0]   i_second_px,
    input  logic signed [MOMENTUM_BITS-1:0]   i_second_py,
    input  logic signed [MOMENTUM_BITS-1:0]   i_second_pz,
    input  logic        [pim_pkg::ROOT_W-1:0] i_first_energy,
    input  logic        [pim_pkg::ROOT_W-1:0] i_second_energy,
    output logic                              o_valid,
    output pim_pkg::t_result                  o_result
);
    import pim_pkg::*;

    localparam int SW     = MOMENTUM_BITS + 1;
    localparam int PD     = LANE_LAT - MOM_LAT;
    localparam int SIDE_W = ESUM_W + 1;

    logic [PIPE_LAT-1:0] r_vld;

    logic signed [SW-1:0] r_psx;
    logic signed [SW-1:0] r_psy;
    logic signed [SW-1:0] r_psz;
    logic [SQ_W-1:0] r_pqx;
    logic [SQ_W-1:0] r_pqy;
    logic [SQ_W-1:0] r_pqz;
    logic [SQ_W-1:0] r_pq01;
    logic [SQ_W-1:0] r_pq2;
    logic [SQ_W-1:0] r_psq;
    logic [SQ_W-1:0] r_pd [0:PD-1];

    logic [ESUM_W-1:0] r_esum1;
    logic [SQ_W-1:0]   r_psq1;
    logic [ESUM_W-1:0] r_esum2;
    logic [SQ_W-1:0]   r_psq2;
    logic [SQ_W-1:0]   r_esq2;
    logic [ESUM_W-1:0] r_esum3;
    logic              r_clamp3;
    logic [SQ_W-1:0]   r_rad3;
    logic [SIDE_W-1:0] r_sd [0:ISQRT_LAT-1];

    logic [ROOT_W-1:0] root;
    logic [ESUM_W-1:0] esum_out;
    logic              clamp_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // summed momentum path, runs beside the energy lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psx  <= SW'(i_first_px) + SW'(i_second_px);
            r_psy  <= SW'(i_first_py) + SW'(i_second_py);
            r_psz  <= SW'(i_first_pz) + SW'(i_second_pz);
            r_pqx  <= sat_sq(mag64(SQ_W'(r_psx)));
            r_pqy  <= sat_sq(mag64(SQ_W'(r_psy)));
            r_pqz  <= sat_sq(mag64(SQ_W'(r_psz)));
            r_pq01 <= sat_add(r_pqx, r_pqy);
            r_pq2  <= r_pqz;
            r_psq  <= sat_add(r_pq01, r_pq2);
            r_pd[0] <= r_psq;
            for (int k = 1; k < PD; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    // radicand from the squared energy sum, clamped at zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_esum1  <= {1'b0, i_first_energy} + {1'b0, i_second_energy};
            r_psq1   <= r_pd[PD-1];
            r_esum2  <= r_esum1;
            r_psq2   <= r_psq1;
            r_esq2   <= sat_sq(SQ_W'(r_esum1));
            r_esum3  <= r_esum2;
            r_clamp3 <= (r_esq2 < r_psq2);
            r_rad3   <= (r_esq2 < r_psq2) ? '0 : (r_esq2 - r_psq2);
            r_sd[0]  <= {r_esum3, r_clamp3};
            for (int k = 1; k < ISQRT_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    pim_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_v    (r_rad3),
        .o_root (root)
    );

    assign esum_out  = r_sd[ISQRT_LAT-1][SIDE_W-1:1];
    assign clamp_out = r_sd[ISQRT_LAT-1][0];

    always_comb begin
        o_result.inv_mass    = (root > ROOT_W'(OUT_MAX)) ? OUT_MAX : root[OUT_W-1:0];
        o_result.pair_energy = (esum_out > ESUM_W'(OUT_MAX)) ? OUT_MAX
                                                              : esum_out[OUT_W-1:0];
        o_result.clamped     = clamp_out;
    end

    assign o_valid = r_vld[PIPE_LAT-1];

endmodule

// ----- rtl/pair_invariant_mass.sv -----
// top level: two energy lanes, merge stage and output register
//
// Computes the invariant mass of a particle pair. Each input word carries two particles
// (three signed momentum components and an unsigned rest mass each, integer MeV); each
// result word gives floor(sqrt((E1+E2)^2 - |p1+p2|^2)), the pair energy E1+E2 and a flag
// that is set when the radicand came out negative and the mass was forced to zero.
// The block accepts one pair every clock cycle except while the pipeline holds. Each
// pair passes through two 32-stage square root pipelines (particle energies, then the
// mass), the stages of squaring and saturating addition and the output register.
// The whole pipeline holds only when a result waits at the output, the downstream
// side is not ready and another result is arriving behind it.
module pair_invariant_mass #(
    parameter int MOMENTUM_BITS = pim_pkg::DEF_MOMENTUM_BITS,
    parameter int MASS_BITS     = pim_pkg::DEF_MASS_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // first_px, first_py, first_pz, first_mass, second_px, second_py, second_pz,
    // second_mass, then zero padding
    input  logic [((6*MOMENTUM_BITS+2*MASS_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // inv_mass, pair_energy, then zero padding
    output logic [pim_pkg::OUT_DATA_W-1:0]               m_tdata,
    // clamped
    output logic [0:0]                                   m_tuser
);
    import pim_pkg::*;

    localparam int MB  = MOMENTUM_BITS;
    localparam int MAB = MASS_BITS;
    localparam int OFS_FPY = MB;
    localparam int OFS_FPZ = 2 * MB;
    localparam int OFS_FM  = 3 * MB;
    localparam int OFS_SPX = 3 * MB + MAB;
    localparam int OFS_SPY = 4 * MB + MAB;
    localparam int OFS_SPZ = 5 * MB + MAB;
    localparam int OFS_SM  = 6 * MB + MAB;

    logic signed [MB-1:0]  first_px;
    logic signed [MB-1:0]  first_py;
    logic signed [MB-1:0]  first_pz;
    logic        [MAB-1:0] first_mass;
    logic signed [MB-1:0]  second_px;
    logic signed [MB-1:0]  second_py;
    logic signed [MB-1:0]  second_pz;
    logic        [MAB-1:0] second_mass;

    logic              en;
    logic              accept;
    logic [ROOT_W-1:0] first_energy;
    logic [ROOT_W-1:0] second_energy;
    logic              mrg_valid;
    t_result           mrg_result;

    logic    r_out_valid;
    t_result r_out;

    assign first_px    = s_tdata[OFS_FPY-1:0];
    assign first_py    = s_tdata[OFS_FPZ-1:OFS_FPY];
    assign first_pz    = s_tdata[OFS_FM-1:OFS_FPZ];
    assign first_mass  = s_tdata[OFS_SPX-1:OFS_FM];
    assign second_px   = s_tdata[OFS_SPY-1:OFS_SPX];
    assign second_py   = s_tdata[OFS_SPZ-1:OFS_SPY];
    assign second_pz   = s_tdata[OFS_SM-1:OFS_SPZ];
    assign second_mass = s_tdata[OFS_SM+MAB-1:OFS_SM];

    // advance unless a finished result would land on one that is still waiting
    assign en       = !r_out_valid || m_tready || !mrg_valid;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    pim_energy_lane #(
        .MOMENTUM_BITS (MOMENTUM_BITS),
        .MASS_BITS     (MASS_BITS)
    ) u_lane_first (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_px     (first_px),
        .i_py     (first_py),
        .i_pz     (first_pz),
        .i_mass   (first_mass),
        .o_energy (first_energy)
    );

    pim_energy_lane #(
        .MOMENTUM_BITS (MOMENTUM_BITS),
        .MASS_BITS     (MASS_BITS)
    ) u_lane_second (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_px     (second_px),
        .i_py     (second_py),
        .i_pz     (second_pz),
        .i_mass   (second_mass),
        .o_energy (second_energy)
    );

    pim_merge #(
        .MOMENTUM_BITS (MOMENTUM_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (accept),
        .i_first_px      (first_px),
        .i_first_py      (first_py),
        .i_first_pz      (first_pz),
        .i_second_px     (second_px),
        .i_second_py     (second_py),
        .i_second_pz     (second_pz),
        .i_first_energy  (first_energy),
        .i_second_energy (second_energy),
        .o_valid         (mrg_valid),
        .o_result        (mrg_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && mrg_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && mrg_valid) begin
            r_out <= mrg_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = OUT_DATA_W'({r_out.pair_energy, r_out.inv_mass});
    assign m_tuser  = r_out.clamped;

endmodule
